[rtl/ttcb_pkg.sv]
// ----------------------------------------------------------------------------
// ttcb_pkg - shared types and codes of the terminal character buffer
// Field widths, mode, key and character codes, and the beat payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package ttcb_pkg;

  // fixed field widths
  localparam int MODE_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int REP_W      = 8;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // item modes
  localparam logic [MODE_W-1:0] MODE_CHAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_KEY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

  // control characters
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_ESC   = 8'h1B;

  // key codes
  localparam logic [CHAR_W-1:0] KEY_HOME   = 8'd0;
  localparam logic [CHAR_W-1:0] KEY_END    = 8'd1;
  localparam logic [CHAR_W-1:0] KEY_TOP    = 8'd2;
  localparam logic [CHAR_W-1:0] KEY_BOTTOM = 8'd3;
  localparam logic [CHAR_W-1:0] KEY_LEFT   = 8'd4;
  localparam logic [CHAR_W-1:0] KEY_RIGHT  = 8'd5;
  localparam logic [CHAR_W-1:0] KEY_UP     = 8'd6;
  localparam logic [CHAR_W-1:0] KEY_DOWN   = 8'd7;
  localparam logic [CHAR_W-1:0] KEY_DELETE = 8'd8;

  // register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b1;
  localparam logic [CFG_DATA_W-1:0] COLS_RESET = 8'd80;
  localparam logic [CFG_DATA_W-1:0] ROWS_RESET = 8'd25;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] code;
    logic [REP_W-1:0]  repeat_count;
    logic [COL_W-1:0]  read_col;
    logic [ROW_W-1:0]  read_row;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0]  caret_col;
    logic [ROW_W-1:0]  caret_row;
    logic [CHAR_W-1:0] read_char;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/ttcb_stream_if.sv]
// ----------------------------------------------------------------------------
// ttcb_stream_if - valid/ready channel
// One beat moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttcb_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/ttcb_ram.sv]
// ----------------------------------------------------------------------------
// ttcb_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/text_terminal_char_buffer.sv]
// ----------------------------------------------------------------------------
// text_terminal_char_buffer - text-mode screen store with a caret
// Character, key and read items in; one result beat (caret, read char) out.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries items (mode, code, repeat_count, read_col, read_row); every
//   accepted item that no cfg write cuts off yields exactly one beat on out_ch
//   with the caret after the item and, for reads, the stored character. One
//   item is worked at a time; in_ch.ready is high only when the sequencer is
//   idle. The screen sits in one single-write, single-read RAM of
//   MAX_COLS*MAX_ROWS bytes. Cursor keys set the caret; reads fetch one entry;
//   printables, LF and CR act once per repeat; a tab writes spaces up to the
//   next tab stop per repeat; backspace and delete shift the rest of the line
//   left (one RAM read-modify-write per column); escape writes spaces to
//   every entry and homes the caret.
//   Reset and every cfg write start a clearing pass over all MAX_COLS*MAX_ROWS
//   entries (4096 at the defaults) that writes spaces and homes the caret;
//   no item is taken until it ends. If out_ch stalls, the result beat waits
//   in the output register; the next item may still be taken and holds in
//   its last step until that beat leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module text_terminal_char_buffer #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 32,
  parameter int TAB_STOP = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  ttcb_stream_if.sink                          in_ch,
  ttcb_stream_if.source                        out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [ttcb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ttcb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ttcb_pkg::*;

  localparam int XW    = $clog2(MAX_COLS);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int YW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [6:0] {
    S_CLEAR    = 7'b0000001,
    S_IDLE     = 7'b0000010,
    S_CHAR     = 7'b0000100,
    S_DEL_RUN  = 7'b0001000,
    S_DEL_FILL = 7'b0010000,
    S_READ     = 7'b0100000,
    S_EMIT     = 7'b1000000
  } state_t;

  // tab stop flags per column, built at elaboration
  function automatic logic [MAX_COLS-1:0] tab_hits();
    logic [MAX_COLS-1:0] v;
    v = '0;
    for (int i = 0; i < MAX_COLS; i++) begin
      v[i] = ((i % TAB_STOP) == 0);
    end
    return v;
  endfunction

  localparam logic [MAX_COLS-1:0] TAB_HIT = tab_hits();

  function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x, input logic [YW-1:0] y);
    return AW'(int'(y) * MAX_COLS + int'(x));
  endfunction

  function automatic logic [CW-1:0] sat_cols(input logic [CFG_DATA_W-1:0] v);
    if (v == '0) begin
      return CW'(1);
    end else if (int'(v) > MAX_COLS) begin
      return CW'(MAX_COLS);
    end
    return CW'(v);
  endfunction

  function automatic logic [RW-1:0] sat_rows(input logic [5:0] v);
    if (v == '0) begin
      return RW'(1);
    end else if (int'(v) > MAX_ROWS) begin
      return RW'(MAX_ROWS);
    end
    return RW'(v);
  endfunction

  // registers
  state_t            state_r, state_nxt;
  logic [XW-1:0]     caret_x_r, caret_x_nxt;
  logic [YW-1:0]     caret_y_r, caret_y_nxt;
  logic [CW-1:0]     cols_r, cols_nxt;
  logic [RW-1:0]     rows_r, rows_nxt;
  logic [CHAR_W-1:0] code_r, code_nxt;
  logic [REP_W-1:0]  rep_r, rep_nxt;
  logic [XW-1:0]     dx_r, dx_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic              clr_emit_r, clr_emit_nxt;
  logic [CHAR_W-1:0] rd_char_r, rd_char_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  // RAM controls
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  ttcb_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (DEPTH)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // sequencer
  always_comb begin
    logic [CW-1:0] x_inc;
    logic [CW-1:0] dx_inc2;
    logic [RW-1:0] y_inc;
    logic          wrap;
    logic [XW-1:0] x_adv;
    logic [YW-1:0] y_nl;
    logic [YW-1:0] y_adv;

    x_inc   = CW'(caret_x_r) + CW'(1);
    dx_inc2 = CW'(dx_r) + CW'(2);
    y_inc   = RW'(caret_y_r) + RW'(1);
    wrap    = (x_inc >= cols_r);
    x_adv   = wrap ? '0 : XW'(x_inc);
    y_nl    = (y_inc >= rows_r) ? '0 : YW'(y_inc);
    y_adv   = wrap ? y_nl : caret_y_r;

    state_nxt     = state_r;
    caret_x_nxt   = caret_x_r;
    caret_y_nxt   = caret_y_r;
    cols_nxt      = cols_r;
    rows_nxt      = rows_r;
    code_nxt      = code_r;
    rep_nxt       = rep_r;
    dx_nxt        = dx_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_emit_nxt  = clr_emit_r;
    rd_char_nxt   = rd_char_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;

    ram_we    = 1'b0;
    ram_waddr = addr_of(caret_x_r, caret_y_r);
    ram_wdata = CH_SPACE;
    ram_re    = 1'b0;
    ram_raddr = addr_of(caret_x_r, caret_y_r);

    case (state_r)
      // write spaces over the whole store
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = clr_emit_r ? S_EMIT : S_IDLE;
        end
      end

      // take an item
      S_IDLE: begin
        if (in_ch.valid) begin
          code_nxt    = in_ch.data.code;
          rep_nxt     = '0;
          rd_char_nxt = '0;
          state_nxt   = S_EMIT;
          case (in_ch.data.mode)
            MODE_CHAR: begin
              rep_nxt   = in_ch.data.repeat_count;
              state_nxt = S_CHAR;
            end
            MODE_KEY: begin
              case (in_ch.data.code)
                KEY_HOME:   caret_x_nxt = '0;
                KEY_END:    caret_x_nxt = XW'(cols_r - CW'(1));
                KEY_TOP:    caret_y_nxt = '0;
                KEY_BOTTOM: caret_y_nxt = YW'(rows_r - RW'(1));
                KEY_LEFT: begin
                  if (caret_x_r != '0) begin
                    caret_x_nxt = caret_x_r - XW'(1);
                  end
                end
                KEY_RIGHT: begin
                  if (x_inc < cols_r) begin
                    caret_x_nxt = XW'(x_inc);
                  end
                end
                KEY_UP: begin
                  if (caret_y_r != '0) begin
                    caret_y_nxt = caret_y_r - YW'(1);
                  end
                end
                KEY_DOWN: begin
                  if (y_inc < rows_r) begin
                    caret_y_nxt = YW'(y_inc);
                  end
                end
                KEY_DELETE: begin
                  if (x_inc < cols_r) begin
                    ram_re    = 1'b1;
                    ram_raddr = addr_of(XW'(x_inc), caret_y_r);
                    dx_nxt    = caret_x_r;
                    state_nxt = S_DEL_RUN;
                  end else begin
                    state_nxt = S_DEL_FILL;
                  end
                end
                default: ;
              endcase
            end
            MODE_READ: begin
              if (CW'(in_ch.data.read_col) < cols_r &&
                  RW'(in_ch.data.read_row) < rows_r) begin
                ram_re    = 1'b1;
                ram_raddr = addr_of(XW'(in_ch.data.read_col), YW'(in_ch.data.read_row));
                state_nxt = S_READ;
              end else begin
                rd_char_nxt = CH_SPACE;
              end
            end
            default: ;
          endcase
        end
      end

      // work the repeats of a character event; a tab repeat runs to the next tab stop, escape ends them all
      S_CHAR: begin
        if (rep_r == '0) begin
          state_nxt = S_EMIT;
        end else begin
          case (code_r)
            CH_BS: begin
              rep_nxt = rep_r - REP_W'(1);
              if (caret_x_r != '0) begin
                caret_x_nxt = caret_x_r - XW'(1);
                dx_nxt      = caret_x_r - XW'(1);
                ram_re      = 1'b1;
                ram_raddr   = addr_of(caret_x_r, caret_y_r);
                state_nxt   = S_DEL_RUN;
              end
            end
            CH_TAB: begin
              ram_we      = 1'b1;
              ram_wdata   = CH_SPACE;
              caret_x_nxt = x_adv;
              caret_y_nxt = y_adv;
              if (TAB_HIT[x_adv]) begin
                rep_nxt = rep_r - REP_W'(1);
              end
            end
            CH_LF: begin
              caret_y_nxt = y_nl;
              rep_nxt     = rep_r - REP_W'(1);
            end
            CH_CR: begin
              caret_x_nxt = '0;
              caret_y_nxt = y_nl;
              rep_nxt     = rep_r - REP_W'(1);
            end
            CH_ESC: begin
              // repeated clears leave the same screen
              caret_x_nxt  = '0;
              caret_y_nxt  = '0;
              rep_nxt      = '0;
              clr_cnt_nxt  = '0;
              clr_emit_nxt = 1'b1;
              state_nxt    = S_CLEAR;
            end
            default: begin
              ram_we      = 1'b1;
              ram_wdata   = code_r;
              caret_x_nxt = x_adv;
              caret_y_nxt = y_adv;
              rep_nxt     = rep_r - REP_W'(1);
            end
          endcase
        end
      end

      // shift the line left: write dx from dx+1, read ahead dx+2
      S_DEL_RUN: begin
        ram_we    = 1'b1;
        ram_waddr = addr_of(dx_r, caret_y_r);
        ram_wdata = ram_rdata;
        if (dx_inc2 < cols_r) begin
          ram_re    = 1'b1;
          ram_raddr = addr_of(XW'(dx_inc2), caret_y_r);
          dx_nxt    = dx_r + XW'(1);
        end else begin
          state_nxt = S_DEL_FILL;
        end
      end

      // space into the last column in use
      S_DEL_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = addr_of(XW'(cols_r - CW'(1)), caret_y_r);
        ram_wdata = CH_SPACE;
        state_nxt = S_CHAR;
      end

      S_READ: begin
        rd_char_nxt = ram_rdata;
        state_nxt   = S_EMIT;
      end

      // hand the result to the output register
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.caret_col = COL_W'(caret_x_r);
          out_data_nxt.caret_row = ROW_W'(caret_y_r);
          out_data_nxt.read_char = rd_char_r;
          state_nxt              = S_IDLE;
        end
      end

      default: begin
        clr_cnt_nxt  = '0;
        clr_emit_nxt = 1'b0;
        state_nxt    = S_CLEAR;
      end
    endcase

    // size write: clear and home
    if (cfg_we) begin
      if (cfg_index == CFG_COLS) begin
        cols_nxt = sat_cols(cfg_wdata);
      end else begin
        rows_nxt = sat_rows(cfg_wdata[5:0]);
      end
      caret_x_nxt  = '0;
      caret_y_nxt  = '0;
      rep_nxt      = '0;
      clr_cnt_nxt  = '0;
      clr_emit_nxt = 1'b0;
      state_nxt    = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      caret_x_r   <= '0;
      caret_y_r   <= '0;
      cols_r      <= sat_cols(COLS_RESET);
      rows_r      <= sat_rows(ROWS_RESET[5:0]);
      rep_r       <= '0;
      clr_cnt_r   <= '0;
      clr_emit_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      caret_x_r   <= caret_x_nxt;
      caret_y_r   <= caret_y_nxt;
      cols_r      <= cols_nxt;
      rows_r      <= rows_nxt;
      rep_r       <= rep_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_emit_r  <= clr_emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    code_r     <= code_nxt;
    dx_r       <= dx_nxt;
    rd_char_r  <= rd_char_nxt;
    out_data_r <= out_data_nxt;
  end

  // checks
  a_caret_col_in_area: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(caret_x_r) < cols_r)
    else $error("caret column outside the area in use");

  a_caret_row_in_area: assert property (@(posedge clk) disable iff (!rst_n)
    RW'(caret_y_r) < rows_r)
    else $error("caret row outside the area in use");

  a_ram_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("line shift reads the entry it writes");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (state_r == S_CLEAR && caret_x_r == '0 && caret_y_r == '0
                && clr_cnt_r == '0))
    else $error("size write did not start a clearing pass");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second beat taken while an item is in work");

endmodule

`default_nettype wire
